// ===== src/dbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbt_pkg
// Shared widths, defaults and the table entry layout of the key debounce table.
// ----------------------------------------------------------------------------
package dbt_pkg;

  // field widths of one press
  localparam int unsigned KeyW  = 8;
  localparam int unsigned TickW = 32;
  localparam int unsigned WinW  = 16;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;

  // default table depth
  localparam int unsigned TableEntriesDefault = 16;

  // one table entry as stored in memory
  typedef struct packed {
    logic [TickW-1:0] tick;
    logic [KeyW-1:0]  key;
  } dbt_entry_t;

  localparam int unsigned EntryW = $bits(dbt_entry_t);

  // bounce when the modular age of the press is below the window
  function automatic logic is_bounce(logic [TickW-1:0] now_tick,
                                     logic [TickW-1:0] last_tick,
                                     logic [WinW-1:0]  window_ticks);
    logic [TickW-1:0] age;
    age = now_tick - last_tick;
    return age < {{(TickW-WinW){1'b0}}, window_ticks};
  endfunction

endpackage

// ===== src/per_key_press_debounce_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_press_debounce_table
// Flags key presses that follow the last accepted press of the same key within
// a tick window; keys are kept in a table in order of first appearance.
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit first)
// s_axis    in   key_code[7:0], now_tick[39:8], window_ticks[55:40]
// m_axis    out  suppressed[0], zero pad [7:1]
//
// For each press the table memory is read one entry a cycle from the oldest
// entry until the key matches or all used entries are read. In the finishing
// cycle a non-bounce match gets the new tick; a new key is appended if it fits.
// Reset clears the entry count and the control state; table contents are not
// cleared, entries past the count are never read.
// A result waits in an output register; a stalled output holds the press
// being finished until the register is free, and the next press is taken once
// the block is back in idle.
// ----------------------------------------------------------------------------
module per_key_press_debounce_table #(
  parameter int unsigned TABLE_ENTRIES = dbt_pkg::TableEntriesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // key_code[7:0], now_tick[39:8], window_ticks[55:40]
  input  logic [dbt_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // suppressed[0], zero pad [7:1]
  output logic [dbt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  import dbt_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(TABLE_ENTRIES);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [AddrW-1:0] cmp_q, cmp_d;
  logic            rvalid_q, rvalid_d;
  logic [KeyW-1:0]  key_q;
  logic [TickW-1:0] now_q;
  logic [WinW-1:0]  win_q;
  logic            out_valid_q, out_valid_d;
  logic            out_supp_q, out_supp_d;

  logic            in_xfer;
  logic            rd_en;
  logic            hit, miss, bounce, slot_free, finish;
  logic            ram_we;
  logic [AddrW-1:0] ram_waddr;
  dbt_entry_t      rd_entry, wr_entry;

  // table memory, one entry per key
  dbt_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .re_i   (rd_en),
    .raddr_i(scan_q[AddrW-1:0]),
    .rdata_o(rd_entry)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // compare the most recently read table entry
  assign hit    = (state_q == StScan) && rvalid_q && (rd_entry.key == key_q);
  assign bounce = is_bounce(now_q, rd_entry.tick, win_q);
  assign miss   = (state_q == StScan) && !hit && (scan_q == used_q);
  assign rd_en  = (state_q == StScan) && !hit && (scan_q < used_q);

  // finish only when the output register can take the result
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign finish    = (hit || miss) && slot_free;

  // write back a refreshed tick or append a new key
  assign ram_we    = finish && ((hit && !bounce) || (miss && (used_q < CntMax)));
  assign ram_waddr = hit ? cmp_q : used_q[AddrW-1:0];
  assign wr_entry  = '{tick: now_q, key: key_q};

  // scan control
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    scan_d   = scan_q;
    cmp_d    = cmp_q;
    rvalid_d = rvalid_q;
    case (state_q)
      StIdle: begin
        rvalid_d = 1'b0;
        scan_d   = '0;
        if (in_xfer) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (!hit) begin
          rvalid_d = rd_en;
        end
        if (rd_en) begin
          cmp_d  = scan_q[AddrW-1:0];
          scan_d = scan_q + 1'b1;
        end
        if (finish) begin
          state_d = StIdle;
          if (miss && (used_q < CntMax)) begin
            used_d = used_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_supp_d  = out_supp_q;
    if (finish) begin
      out_valid_d = 1'b1;
      out_supp_d  = hit && bounce;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      scan_q      <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      scan_q      <= scan_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_q      <= cmp_d;
    out_supp_q <= out_supp_d;
    if (in_xfer) begin
      key_q <= s_axis_tdata_i[KeyW-1:0];
      now_q <= s_axis_tdata_i[KeyW+TickW-1:KeyW];
      win_q <= s_axis_tdata_i[KeyW+TickW+WinW-1:KeyW+TickW];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-1){1'b0}}, out_supp_q};

  // checks on the scan and the table count
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntMax) else $error("entry count above table depth");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (state_q == StIdle) && out_valid_q)
    else $error("finished press did not reach the output register");

  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> rvalid_q) else $error("issued table read not marked valid");

  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && miss && (used_q < CntMax)) |=> (used_q == $past(used_q) + 1'b1))
    else $error("appended key did not advance the entry count");

  a_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StScan) && slot_free)
    else $error("table write outside a finishing scan");

endmodule

// ===== src/dbt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-key press debounce table. Presses go in
// over the input stream; a mirror of the key table predicts the suppressed
// flag of every press, and each result transfer is checked against the
// oldest prediction. Directed presses hit window edges, tick wrap, the zero
// window and a full table, then random presses run under three idle mixes
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import dbt_pkg::*;

  localparam int Entries       = TableEntriesDefault;
  localparam int LatencyCycles = Entries + 8;
  localparam int HoldCycles    = 80;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // key_code[7:0], now_tick[39:8], window_ticks[55:40]
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // suppressed[0], zero pad [7:1]
  logic [OutDataW-1:0] m_axis_tdata_o;

  // mirror of the key table and the queue of predicted flags
  logic [KeyW-1:0]     mirror_keys  [Entries];
  logic [TickW-1:0]    mirror_ticks [Entries];
  int                  mirror_used = 0;
  logic                bounce_q [$];

  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  logic                hold_active   = 1'b0;
  event                hold_off_ev;

  int                  mismatch_count  = 0;
  int                  press_count     = 0;
  int                  result_count    = 0;
  int                  bounce_seen     = 0;
  int                  hit_count       = 0;
  int                  full_miss_count = 0;
  logic [OutDataW-1:0] want_tdata;

  per_key_press_debounce_table #(
    .TABLE_ENTRIES(Entries)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // table lookup, bounce decision and table update for one press
  function automatic logic predict_bounce(input logic [KeyW-1:0]  key,
                                          input logic [TickW-1:0] now,
                                          input logic [WinW-1:0]  win);
    logic [TickW-1:0] age;
    logic [TickW-1:0] win_ext;
    logic             flag;
    flag    = 1'b0;
    win_ext = {{(TickW-WinW){1'b0}}, win};
    for (int i = 0; i < mirror_used; i++) begin
      if (mirror_keys[i] == key) begin
        age = now - mirror_ticks[i];
        if (age < win_ext) begin
          flag = 1'b1;
        end else begin
          mirror_ticks[i] = now;
        end
        hit_count++;
        return flag;
      end
    end
    if (mirror_used < Entries) begin
      mirror_keys[mirror_used]  = key;
      mirror_ticks[mirror_used] = now;
      mirror_used++;
    end else begin
      full_miss_count++;
    end
    return flag;
  endfunction

  // one press transfer, with random idle cycles ahead of it
  task automatic send_press(input logic [KeyW-1:0]  key,
                            input logic [TickW-1:0] now,
                            input logic [WinW-1:0]  win);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {win, now, key};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bounce_q.push_back(predict_bounce(key, now, win));
    press_count++;
  endtask

  // sender pause until every predicted flag has come back
  task automatic wait_results_done();
    s_axis_tvalid_i <= 1'b0;
    while (bounce_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // mostly presses of known keys with ticks placed around the window
  task automatic send_random_press();
    logic [KeyW-1:0]  key;
    logic [TickW-1:0] now;
    logic [WinW-1:0]  win;
    logic [TickW-1:0] win_ext;
    int               idx;
    case ($urandom_range(9))
      0:       win = '0;
      1:       win = '1;
      default: win = WinW'($urandom_range(16'hFFFF));
    endcase
    win_ext = {{(TickW-WinW){1'b0}}, win};
    if ($urandom_range(99) < 80 && mirror_used > 0) begin
      idx = $urandom_range(mirror_used - 1);
      key = mirror_keys[idx];
      case ($urandom_range(5))
        0:       now = mirror_ticks[idx] + win_ext - 32'd1;
        1:       now = mirror_ticks[idx] + win_ext;
        2:       now = mirror_ticks[idx] + $urandom_range(win_ext);
        3:       now = mirror_ticks[idx] + $urandom_range(3);
        4:       now = mirror_ticks[idx] - $urandom_range(1, 1000);
        default: now = $urandom();
      endcase
    end else begin
      key = KeyW'($urandom_range(255));
      now = $urandom();
    end
    send_press(key, now, win);
  endtask

  task automatic test_tick_window_edges();
    send_press(8'h00, 32'hFFFF_FFF0, 16'hFFFF);  // first key into an empty table
    send_press(8'h00, 32'h0000_0005, 16'h0100);  // tick wrapped, still inside window
    send_press(8'h00, 32'h0000_0005, 16'h0000);  // zero window never suppresses
    send_press(8'h00, 32'h0000_0004, 16'hFFFF);  // tick moved backwards: huge age
    send_press(8'hFF, 32'h0000_1000, 16'hFFFF);
    send_press(8'hFF, 32'h0001_0FFE, 16'hFFFF);  // one tick short of the window
    send_press(8'hFF, 32'h0001_0FFF, 16'hFFFF);  // age equal to the window
    send_press(8'hFF, 32'h0001_0FFF, 16'h0001);  // zero age, window of one
    send_press(8'hFF, 32'h0001_1009, 16'h0014);  // bounce, stored tick kept
    send_press(8'hFF, 32'h0001_1018, 16'h0014);  // age counted from the kept tick
  endtask

  task automatic test_table_full();
    logic [KeyW-1:0] fill_keys [14] = '{8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h01,
                                        8'h80, 8'h7F, 8'hFE, 8'h12, 8'h34, 8'hC3, 8'h3C};
    foreach (fill_keys[i]) begin
      send_press(fill_keys[i], $urandom(), WinW'($urandom_range(16'hFFFF)));
    end
    // unknown key on a full table is never stored
    send_press(8'h7E, 32'h2000_0000, 16'hFFFF);
    send_press(8'h7E, 32'h2000_0001, 16'hFFFF);
    // bounce on the last entry, the longest walk
    send_press(8'h3C, mirror_ticks[Entries-1] + 32'd1, 16'hFFFF);
  endtask

  task automatic test_random_presses(input int count);
    repeat (count) begin
      if ($urandom_range(99) == 0) begin
        wait_results_done();
      end
      send_random_press();
    end
  endtask

  // long output hold-off while presses keep coming, then a full drain
  task automatic test_output_backpressure();
    int unsigned saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    wait_results_done();
    -> hold_off_ev;
    repeat (12) send_random_press();
    send_idle_pct = saved_idle;
    wait_results_done();
  endtask

  // long output hold-off, counted in cycles
  initial begin
    forever begin
      @(hold_off_ev);
      hold_active <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  // output-side ready
  always @(posedge clk_i) begin
    if (hold_active) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (bounce_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result transfer: tdata %h", m_axis_tdata_o);
        end
      end else begin
        want_tdata = {{(OutDataW-1){1'b0}}, bounce_q.pop_front()};
        if (m_axis_tdata_o !== want_tdata) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: suppressed expected %h, got %h", result_count,
                     want_tdata, m_axis_tdata_o);
          end
        end
        if (want_tdata[0]) begin
          bounce_seen++;
        end
        result_count++;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 83;
    test_tick_window_edges();
    test_table_full();
    test_random_presses(400);

    send_idle_pct = 83;
    recv_idle_pct = 21;
    test_output_backpressure();
    test_random_presses(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_presses(410);

    wait_results_done();
    $display("covered %0d presses and %0d results: %0d suppressed, %0d table hits,",
             press_count, result_count, bounce_seen, hit_count);
    $display("%0d misses on a full table, three idle mixes and one long output hold-off",
             full_miss_count);
    if (mismatch_count == 0 && bounce_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
